// File: rtl/tsdf_pkg.sv
package tsdf_pkg;

  // Widths of the result fields
  localparam int unsigned POS_W   = 16;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned TS_W    = 62;

  localparam int unsigned MAX_CAPTURE_DEF = 65535;

  // Transport stream packet size and its reciprocal: 188 = 4 * 47
  localparam int unsigned TS_PACKET_BYTES = 188;
  localparam int unsigned TS_PRE_SHIFT    = 2;
  localparam int unsigned TS_ODD_FACTOR   = TS_PACKET_BYTES / (1 << TS_PRE_SHIFT);
  localparam int unsigned TS_RECIP_SHIFT  = 20;
  localparam int unsigned TS_RECIP        =
    ((1 << TS_RECIP_SHIFT) + TS_ODD_FACTOR - 1) / TS_ODD_FACTOR;

  // Link and protocol header constants
  localparam logic [4:0]  ETH_HDR_BYTES    = 5'd14;
  localparam logic [4:0]  VLAN_HDR_BYTES   = 5'd18;
  localparam logic [4:0]  LOOP_HDR_BYTES   = 5'd4;
  localparam logic [4:0]  COOKED_HDR_BYTES = 5'd16;
  localparam logic [15:0] ETH_TYPE_HI_AT   = 16'd12;
  localparam logic [15:0] ETH_TYPE_LO_AT   = 16'd13;
  localparam logic [15:0] VLAN_TPID        = 16'h8100;
  localparam logic [3:0]  IPV4_VERSION     = 4'd4;
  localparam logic [7:0]  IP_PROTO_UDP     = 8'd17;
  localparam logic [15:0] IP_PROTO_AT      = 16'd9;
  localparam logic [15:0] UDP_LEN_AT       = 16'd4;
  localparam logic [15:0] IPV4_MIN_HDR     = 16'd20;
  localparam logic [15:0] UDP_HDR_BYTES    = 16'd8;
  localparam logic [6:0]  RTP_FIXED_BYTES  = 7'd12;
  localparam logic [7:0]  RTP_EXT_LEN_AT   = 8'd14;
  localparam logic [15:0] RTP_EXT_HDR      = 16'd4;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [9:0]  NS_PER_US  = 10'd1000;

  typedef enum logic [1:0] {
    LK_ETHERNET    = 2'd0,
    LK_LOOPBACK    = 2'd1,
    LK_COOKED      = 2'd2,
    LK_UNSUPPORTED = 2'd3
  } link_kind_t;

  typedef enum logic [2:0] {
    ST_RAW_TS      = 3'd0,
    ST_RTP_TS      = 3'd1,
    ST_TOO_SHORT   = 3'd2,
    ST_NOT_UDP     = 3'd3,
    ST_BAD_UDP_LEN = 3'd4,
    ST_NOT_ALIGNED = 3'd5,
    ST_NO_LINK     = 3'd6
  } frame_status_t;

  // Header fields gathered over one frame, as they stand after its last byte
  typedef struct packed {
    logic [POS_W-1:0] caplen;
    logic [4:0]       link_hdr_len;
    logic             ip_version_ok;
    logic [3:0]       ip_hdr_words;
    logic [15:0]      udp_len;
    logic [7:0]       rtp_first;
    logic [15:0]      ext_len;
    logic             proto_udp;
  } frame_hdr_t;

endpackage

// File: rtl/tsdf_hdr.sv
// Per-byte header tracker: follows the byte position and picks header fields.
module tsdf_hdr #(
  parameter int unsigned MAX_CAPTURE = tsdf_pkg::MAX_CAPTURE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  tsdf_pkg::link_kind_t  link_kind,
  output tsdf_pkg::frame_hdr_t  snap
);

  logic [tsdf_pkg::POS_W-1:0] pos_r, pos_nxt, pos_upd;
  logic [4:0]  lh_r, lh_nxt, lh_upd, lh_cur;
  logic [7:0]  eth_hi_r, eth_hi_nxt, eth_hi_upd;
  logic        ipok_r, ipok_nxt, ipok_upd;
  logic [3:0]  ihl_r, ihl_nxt, ihl_upd;
  logic [15:0] udp_len_r, udp_len_nxt, udp_len_upd;
  logic [7:0]  rtp_r, rtp_nxt, rtp_upd;
  logic [15:0] ext_len_r, ext_len_nxt, ext_len_upd;
  logic        udp_r, udp_nxt, udp_upd;
  logic [6:0]  udp_start;
  logic [6:0]  pay_start;
  logic [7:0]  ext_at;
  logic [15:0] lh16;

  always_comb begin
    pos_upd     = pos_r;
    lh_upd      = lh_r;
    eth_hi_upd  = eth_hi_r;
    ipok_upd    = ipok_r;
    ihl_upd     = ihl_r;
    udp_len_upd = udp_len_r;
    rtp_upd     = rtp_r;
    ext_len_upd = ext_len_r;
    udp_upd     = udp_r;
    lh_cur      = lh_r;
    lh16        = {11'd0, lh_r};
    udp_start   = {2'b00, lh_r} + {1'b0, ihl_r, 2'b00};
    pay_start   = udp_start + 7'd8;
    ext_at      = {1'b0, pay_start} + tsdf_pkg::RTP_EXT_LEN_AT + {2'b00, rtp_r[3:0], 2'b00};

    if (pos_r < tsdf_pkg::POS_W'(MAX_CAPTURE)) begin
      pos_upd = pos_r + 1'b1;
      // Latch the link header length on the first byte of the frame
      if (pos_r == '0) begin
        unique case (link_kind)
          tsdf_pkg::LK_ETHERNET:    lh_cur = tsdf_pkg::ETH_HDR_BYTES;
          tsdf_pkg::LK_LOOPBACK:    lh_cur = tsdf_pkg::LOOP_HDR_BYTES;
          tsdf_pkg::LK_COOKED:      lh_cur = tsdf_pkg::COOKED_HDR_BYTES;
          tsdf_pkg::LK_UNSUPPORTED: lh_cur = '0;
        endcase
      end
      lh_upd    = lh_cur;
      lh16      = {11'd0, lh_cur};
      udp_start = {2'b00, lh_cur} + {1'b0, ihl_r, 2'b00};
      pay_start = udp_start + 7'd8;
      ext_at    = {1'b0, pay_start} + tsdf_pkg::RTP_EXT_LEN_AT + {2'b00, rtp_r[3:0], 2'b00};

      if (lh_cur != '0) begin
        if (lh_cur == tsdf_pkg::ETH_HDR_BYTES && pos_r == tsdf_pkg::ETH_TYPE_HI_AT) begin
          eth_hi_upd = data_byte;
        end
        if (lh_cur == tsdf_pkg::ETH_HDR_BYTES && pos_r == tsdf_pkg::ETH_TYPE_LO_AT &&
            {eth_hi_r, data_byte} == tsdf_pkg::VLAN_TPID) begin
          lh_upd = tsdf_pkg::VLAN_HDR_BYTES;
        end
        if (pos_r == lh16) begin
          ipok_upd = (data_byte[7:4] == tsdf_pkg::IPV4_VERSION);
          ihl_upd  = data_byte[3:0];
        end else if (pos_r > lh16) begin
          if (pos_r == lh16 + tsdf_pkg::IP_PROTO_AT) begin
            udp_upd = (data_byte == tsdf_pkg::IP_PROTO_UDP);
          end
          if (pos_r == {9'd0, udp_start} + tsdf_pkg::UDP_LEN_AT) begin
            udp_len_upd[15:8] = data_byte;
          end
          if (pos_r == {9'd0, udp_start} + tsdf_pkg::UDP_LEN_AT + 16'd1) begin
            udp_len_upd[7:0] = data_byte;
          end
          if (pos_r == {9'd0, pay_start}) begin
            rtp_upd = data_byte;
          end else if (pos_r > {9'd0, pay_start}) begin
            if (pos_r == {8'd0, ext_at}) begin
              ext_len_upd[15:8] = data_byte;
            end
            if (pos_r == {8'd0, ext_at} + 16'd1) begin
              ext_len_upd[7:0] = data_byte;
            end
          end
        end
      end
    end
  end

  always_comb begin
    snap.caplen        = pos_upd;
    snap.link_hdr_len  = lh_upd;
    snap.ip_version_ok = ipok_upd;
    snap.ip_hdr_words  = ihl_upd;
    snap.udp_len       = udp_len_upd;
    snap.rtp_first     = rtp_upd;
    snap.ext_len       = ext_len_upd;
    snap.proto_udp     = udp_upd;
  end

  // Hold when idle, advance on a byte, clear after the last byte
  always_comb begin
    pos_nxt     = pos_r;
    lh_nxt      = lh_r;
    eth_hi_nxt  = eth_hi_r;
    ipok_nxt    = ipok_r;
    ihl_nxt     = ihl_r;
    udp_len_nxt = udp_len_r;
    rtp_nxt     = rtp_r;
    ext_len_nxt = ext_len_r;
    udp_nxt     = udp_r;
    if (take) begin
      if (last_byte) begin
        pos_nxt     = '0;
        lh_nxt      = '0;
        eth_hi_nxt  = '0;
        ipok_nxt    = 1'b0;
        ihl_nxt     = '0;
        udp_len_nxt = '0;
        rtp_nxt     = '0;
        ext_len_nxt = '0;
        udp_nxt     = 1'b0;
      end else begin
        pos_nxt     = pos_upd;
        lh_nxt      = lh_upd;
        eth_hi_nxt  = eth_hi_upd;
        ipok_nxt    = ipok_upd;
        ihl_nxt     = ihl_upd;
        udp_len_nxt = udp_len_upd;
        rtp_nxt     = rtp_upd;
        ext_len_nxt = ext_len_upd;
        udp_nxt     = udp_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      lh_r      <= '0;
      eth_hi_r  <= '0;
      ipok_r    <= 1'b0;
      ihl_r     <= '0;
      udp_len_r <= '0;
      rtp_r     <= '0;
      ext_len_r <= '0;
      udp_r     <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      lh_r      <= lh_nxt;
      eth_hi_r  <= eth_hi_nxt;
      ipok_r    <= ipok_nxt;
      ihl_r     <= ihl_nxt;
      udp_len_r <= udp_len_nxt;
      rtp_r     <= rtp_nxt;
      ext_len_r <= ext_len_nxt;
      udp_r     <= udp_nxt;
    end
  end

endmodule

// File: rtl/tsdf_div188.sv
// Divide by the TS packet size through a registered reciprocal multiply.
module tsdf_div188 (
  input  logic                         clk,
  input  logic                         load,
  input  logic [15:0]                  x,
  output logic [tsdf_pkg::COUNT_W-1:0] q,
  output logic                         exact
);

  localparam logic [14:0] RECIP = 15'(tsdf_pkg::TS_RECIP);
  localparam int unsigned PROD_W = 29;

  logic [15:0]       x_r, x_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [16:0]       back;

  // Drop the factor of four first, then multiply by the reciprocal of 47
  assign x_nxt    = x;
  assign prod_nxt = PROD_W'(x[15:tsdf_pkg::TS_PRE_SHIFT]) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= x_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign q     = prod_r[PROD_W-1:tsdf_pkg::TS_RECIP_SHIFT];
  assign back  = {8'd0, q} * 17'(tsdf_pkg::TS_PACKET_BYTES);
  assign exact = ({1'b0, x_r} == back);

endmodule

// File: rtl/ts_over_udp_rtp_deframer.sv
// Channel  Dir  Signals                         Contents (lowest bit first)
// in_      in   tvalid tready tdata[63:0] tlast data_byte, capture_seconds, capture_micros;
//                                               tlast = last_byte
// out_     out  tvalid tready tdata[87:0] tuser payload_offset, packet_count, timestamp_ns;
//                                               tuser = frame_status
// cfg_     in   wr_en wr_data[1:0]              link_kind
//
// One frame byte is taken every cycle while in_tready is high; each byte only updates the position and
// header registers. The last byte of a frame enters a four-register result pipe
// (snapshot, classify and multiply, reciprocal divide and sum, result), so its
// result shows on out_tvalid once it reaches the result register.
// Reset (rst_n low at a clock edge) selects Ethernet and clears frame state and
// the result pipe. in_tready falls only when all four result registers hold a
// result that waits on out_tready; bytes that end no frame pass freely otherwise.
module ts_over_udp_rtp_deframer #(
  parameter int unsigned MAX_CAPTURE = tsdf_pkg::MAX_CAPTURE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // data_byte[7:0], capture_seconds[39:8], capture_micros[59:40]
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // payload_offset[15:0], packet_count[24:16], timestamp_ns[86:25]
  output logic [2:0]  out_tuser,  // frame_status[2:0]
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data // link_kind
);

  localparam int unsigned POS_W   = tsdf_pkg::POS_W;
  localparam int unsigned COUNT_W = tsdf_pkg::COUNT_W;
  localparam int unsigned TS_W    = tsdf_pkg::TS_W;

  // Configuration
  tsdf_pkg::link_kind_t link_kind_r, link_kind_nxt;

  // Pipe control
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy_out;
  logic take, take_last, load2, load3, load_out;

  // Byte tracker snapshot
  tsdf_pkg::frame_hdr_t snap;

  // Stage 1: snapshot of the finished frame
  tsdf_pkg::frame_hdr_t s1_hdr_r;
  logic [31:0]          s1_secs_r;
  logic [19:0]          s1_us_r;

  // Stage 2: classification, lengths and timestamp products
  tsdf_pkg::frame_status_t s2_pre_r, s2_pre_nxt;
  logic                    s2_ok_r, s2_ok_nxt;
  logic                    s2_rtp_fit_r, s2_rtp_fit_nxt;
  logic [6:0]              s2_off_raw_r, s2_off_raw_nxt;
  logic [15:0]             s2_off_rtp_r, s2_off_rtp_nxt;
  logic [15:0]             s2_plen_r, s2_plen_nxt;
  logic [15:0]             s2_rest_r, s2_rest_nxt;
  logic [TS_W-1:0]         s2_ts_sec_r, s2_ts_sec_nxt;
  logic [29:0]             s2_ts_us_r, s2_ts_us_nxt;

  // Stage 3: divide and timestamp sum
  tsdf_pkg::frame_status_t s3_pre_r;
  logic                    s3_ok_r;
  logic                    s3_rtp_fit_r;
  logic [6:0]              s3_off_raw_r;
  logic [15:0]             s3_off_rtp_r;
  logic [TS_W-1:0]         s3_ts_r, s3_ts_nxt;

  logic [COUNT_W-1:0] qa, qb;
  logic               a_exact, b_exact;

  // Result register
  tsdf_pkg::frame_status_t out_status_r, out_status_nxt;
  logic [POS_W-1:0]        out_offset_r, out_offset_nxt;
  logic [COUNT_W-1:0]      out_count_r, out_count_nxt;
  logic [TS_W-1:0]         out_ts_r;

  // Stage 2 working signals
  logic [6:0]  lh7, hdr_end, pstart, rtp_base;
  logic [15:0] min_frame, plen;
  logic [16:0] udp_end;
  logic [18:0] rl;
  logic        has_min, has_ext;

  // ---------------------------------------------------------------------------
  // Handshake: each stage moves on when the one after it is empty or moving.
  // ---------------------------------------------------------------------------
  assign rdy_out   = !out_v_r || out_tready;
  assign rdy3      = !s3_v_r || rdy_out;
  assign rdy2      = !s2_v_r || rdy3;
  assign rdy1      = !s1_v_r || rdy2;
  assign in_tready = rdy1;
  assign take      = in_tvalid && rdy1;
  assign take_last = take && in_tlast;
  assign load2     = rdy2 && s1_v_r;
  assign load3     = rdy3 && s2_v_r;
  assign load_out  = rdy_out && s3_v_r;

  assign link_kind_nxt = cfg_wr_en ? tsdf_pkg::link_kind_t'(cfg_wr_data) : link_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_kind_r <= tsdf_pkg::LK_ETHERNET;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      link_kind_r <= link_kind_nxt;
      if (rdy1) begin
        s1_v_r <= take_last;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy_out) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte tracker: position, link header length and the header fields.
  // ---------------------------------------------------------------------------
  tsdf_hdr #(
    .MAX_CAPTURE (MAX_CAPTURE)
  ) u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_tdata[7:0]),
    .last_byte (in_tlast),
    .link_kind (link_kind_r),
    .snap      (snap)
  );

  // Capture the frame's fields and its time on the last byte
  always_ff @(posedge clk) begin
    if (take_last) begin
      s1_hdr_r  <= snap;
      s1_secs_r <= in_tdata[39:8];
      s1_us_r   <= in_tdata[59:40];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: ordered checks, UDP payload length and RTP header length.
  // ---------------------------------------------------------------------------
  always_comb begin
    lh7       = {2'b00, s1_hdr_r.link_hdr_len};
    hdr_end   = lh7 + {1'b0, s1_hdr_r.ip_hdr_words, 2'b00};
    pstart    = hdr_end + 7'(tsdf_pkg::UDP_HDR_BYTES);
    min_frame = {9'd0, lh7} + tsdf_pkg::IPV4_MIN_HDR + tsdf_pkg::UDP_HDR_BYTES;
    udp_end   = {1'b0, s1_hdr_r.udp_len} + {10'd0, hdr_end};
    plen      = s1_hdr_r.udp_len - tsdf_pkg::UDP_HDR_BYTES;

    // RTP: fixed part plus CSRC list, then the extension if it fits
    rtp_base = tsdf_pkg::RTP_FIXED_BYTES + {1'b0, s1_hdr_r.rtp_first[3:0], 2'b00};
    has_min  = plen >= {9'd0, tsdf_pkg::RTP_FIXED_BYTES};
    has_ext  = s1_hdr_r.rtp_first[4] && (plen >= {9'd0, rtp_base} + tsdf_pkg::RTP_EXT_HDR);
    if (has_ext) begin
      rl = {12'd0, rtp_base} + 19'(tsdf_pkg::RTP_EXT_HDR) + {1'b0, s1_hdr_r.ext_len, 2'b00};
    end else if (has_min) begin
      rl = {12'd0, rtp_base};
    end else begin
      rl = '0;
    end
    s2_rtp_fit_nxt = has_min && (rl < {3'd0, plen});
    s2_rest_nxt    = plen - rl[15:0];
    s2_off_rtp_nxt = {9'd0, pstart} + rl[15:0];
    s2_off_raw_nxt = pstart;
    s2_plen_nxt    = plen;

    s2_ok_nxt  = 1'b0;
    s2_pre_nxt = tsdf_pkg::ST_RAW_TS;
    priority if (s1_hdr_r.link_hdr_len == '0) begin
      s2_pre_nxt = tsdf_pkg::ST_NO_LINK;
    end else if (s1_hdr_r.caplen < min_frame) begin
      s2_pre_nxt = tsdf_pkg::ST_TOO_SHORT;
    end else if (!s1_hdr_r.ip_version_ok || !s1_hdr_r.proto_udp) begin
      s2_pre_nxt = tsdf_pkg::ST_NOT_UDP;
    end else if (s1_hdr_r.caplen < {9'd0, pstart}) begin
      s2_pre_nxt = tsdf_pkg::ST_TOO_SHORT;
    end else if (s1_hdr_r.udp_len <= tsdf_pkg::UDP_HDR_BYTES ||
                 udp_end > {1'b0, s1_hdr_r.caplen}) begin
      s2_pre_nxt = tsdf_pkg::ST_BAD_UDP_LEN;
    end else begin
      s2_ok_nxt = 1'b1;
    end

    s2_ts_sec_nxt = TS_W'(s1_secs_r) * TS_W'(tsdf_pkg::NS_PER_SEC);
    s2_ts_us_nxt  = 30'(s1_us_r) * 30'(tsdf_pkg::NS_PER_US);
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_pre_r     <= s2_pre_nxt;
      s2_ok_r      <= s2_ok_nxt;
      s2_rtp_fit_r <= s2_rtp_fit_nxt;
      s2_off_raw_r <= s2_off_raw_nxt;
      s2_off_rtp_r <= s2_off_rtp_nxt;
      s2_plen_r    <= s2_plen_nxt;
      s2_rest_r    <= s2_rest_nxt;
      s2_ts_sec_r  <= s2_ts_sec_nxt;
      s2_ts_us_r   <= s2_ts_us_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide the payload and the RTP remainder by the packet size.
  // ---------------------------------------------------------------------------
  tsdf_div188 u_div_raw (
    .clk   (clk),
    .load  (load3),
    .x     (s2_plen_r),
    .q     (qa),
    .exact (a_exact)
  );

  tsdf_div188 u_div_rtp (
    .clk   (clk),
    .load  (load3),
    .x     (s2_rest_r),
    .q     (qb),
    .exact (b_exact)
  );

  assign s3_ts_nxt = s2_ts_sec_r + TS_W'(s2_ts_us_r);

  always_ff @(posedge clk) begin
    if (load3) begin
      s3_pre_r     <= s2_pre_r;
      s3_ok_r      <= s2_ok_r;
      s3_rtp_fit_r <= s2_rtp_fit_r;
      s3_off_raw_r <= s2_off_raw_r;
      s3_off_rtp_r <= s2_off_rtp_r;
      s3_ts_r      <= s3_ts_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result: raw TS wins over RTP; offset and count stay zero when dropped.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_status_nxt = tsdf_pkg::ST_NOT_ALIGNED;
    out_offset_nxt = '0;
    out_count_nxt  = '0;
    priority if (!s3_ok_r) begin
      out_status_nxt = s3_pre_r;
    end else if (a_exact) begin
      out_status_nxt = tsdf_pkg::ST_RAW_TS;
      out_offset_nxt = {9'd0, s3_off_raw_r};
      out_count_nxt  = qa;
    end else if (s3_rtp_fit_r && b_exact) begin
      out_status_nxt = tsdf_pkg::ST_RTP_TS;
      out_offset_nxt = s3_off_rtp_r;
      out_count_nxt  = qb;
    end else begin
      out_status_nxt = tsdf_pkg::ST_NOT_ALIGNED;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= out_status_nxt;
      out_offset_r <= out_offset_nxt;
      out_count_r  <= out_count_nxt;
      out_ts_r     <= s3_ts_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_ts_r, out_count_r, out_offset_r};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_last_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> s1_v_r)
    else $error("last byte did not enter the result pipe");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_v_r && s2_v_r && s3_v_r && out_v_r && !out_tready)
    else $error("input stalled with room in the result pipe");

  a_dropped_frame_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != tsdf_pkg::ST_RAW_TS) && (out_tuser != tsdf_pkg::ST_RTP_TS)
      |-> out_tdata[24:0] == '0)
    else $error("dropped frame carries an offset or a packet count");

endmodule

// File: dv/deframer_check_pkg.sv
package deframer_check_pkg;

  import tsdf_pkg::*;

  // One expected verdict for one captured frame
  typedef struct {
    frame_status_t     status;
    logic [POS_W-1:0]  offset;
    logic [COUNT_W-1:0] count;
    logic [TS_W-1:0]   ts_ns;
  } verdict_t;

  class frame_verdict_board;
    link_kind_t  link_kind;
    int unsigned pos, hdr_len, eth_type, ihl, udp_len, rtp_first, ext_len;
    bit          ver_ok, is_udp;
    verdict_t    due[$];
    int unsigned errors;

    function new();
      link_kind = LK_ETHERNET;
      errors    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos       = 0;
      hdr_len   = 0;
      eth_type  = 0;
      ver_ok    = 0;
      ihl       = 0;
      udp_len   = 0;
      rtp_first = 0;
      ext_len   = 0;
      is_udp    = 0;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function void take_byte(int unsigned idx, int unsigned b);
      int unsigned lh, udp_at, pay_at, ext_at;
      if (idx == 0) begin
        case (link_kind)
          LK_ETHERNET: hdr_len = ETH_HDR_BYTES;
          LK_LOOPBACK: hdr_len = LOOP_HDR_BYTES;
          LK_COOKED:   hdr_len = COOKED_HDR_BYTES;
          default:     hdr_len = 0;
        endcase
      end
      lh = hdr_len;
      if (lh == 0) return;
      if (lh == ETH_HDR_BYTES && idx == ETH_TYPE_HI_AT) eth_type = b << 8;
      if (lh == ETH_HDR_BYTES && idx == ETH_TYPE_LO_AT) begin
        eth_type = (eth_type | b) & 16'hFFFF;
        if (eth_type == VLAN_TPID) hdr_len = VLAN_HDR_BYTES;
        return;
      end
      if (idx < lh) return;
      if (idx == lh) begin
        ver_ok = ((b >> 4) == IPV4_VERSION);
        ihl    = b & 4'hF;
        return;
      end
      if (idx == lh + IP_PROTO_AT) is_udp = (b == IP_PROTO_UDP);
      udp_at = lh + 4 * ihl;
      if (idx == udp_at + UDP_LEN_AT) udp_len = (b << 8) & 16'hFF00;
      if (idx == udp_at + UDP_LEN_AT + 1) udp_len = (udp_len & 16'hFF00) | b;
      pay_at = udp_at + UDP_HDR_BYTES;
      if (idx == pay_at) begin
        rtp_first = b;
        return;
      end
      if (idx > pay_at) begin
        ext_at = pay_at + RTP_EXT_LEN_AT + 4 * (rtp_first & 8'h0F);
        if (idx == ext_at) ext_len = (b << 8) & 16'hFF00;
        if (idx == ext_at + 1) ext_len = (ext_len & 16'hFF00) | b;
      end
    endfunction

    function verdict_t judge(logic [31:0] secs, logic [19:0] us);
      verdict_t    v;
      int unsigned iphl, plen, pstart, rl;
      logic [63:0] ns;
      v.offset = '0;
      v.count  = '0;
      iphl     = 4 * ihl;
      if (hdr_len == 0) begin
        v.status = ST_NO_LINK;
      end else if (pos < hdr_len + IPV4_MIN_HDR + UDP_HDR_BYTES) begin
        v.status = ST_TOO_SHORT;
      end else if (!ver_ok || !is_udp) begin
        v.status = ST_NOT_UDP;
      end else if (pos < hdr_len + iphl + UDP_HDR_BYTES) begin
        v.status = ST_TOO_SHORT;
      end else if (udp_len <= UDP_HDR_BYTES || hdr_len + iphl + udp_len > pos) begin
        v.status = ST_BAD_UDP_LEN;
      end else begin
        plen   = udp_len - UDP_HDR_BYTES;
        pstart = hdr_len + iphl + UDP_HDR_BYTES;
        if (plen % TS_PACKET_BYTES == 0) begin
          v.status = ST_RAW_TS;
          v.offset = POS_W'(pstart);
          v.count  = COUNT_W'(plen / TS_PACKET_BYTES);
        end else begin
          rl = 0;
          if (plen >= RTP_FIXED_BYTES) begin
            rl = RTP_FIXED_BYTES + 4 * (rtp_first & 8'h0F);
            if ((rtp_first & 8'h10) != 0 && plen >= rl + RTP_EXT_HDR)
              rl += RTP_EXT_HDR + 4 * ext_len;
          end
          if (rl > 0 && rl < plen && (plen - rl) % TS_PACKET_BYTES == 0) begin
            v.status = ST_RTP_TS;
            v.offset = POS_W'(pstart + rl);
            v.count  = COUNT_W'((plen - rl) / TS_PACKET_BYTES);
          end else begin
            v.status = ST_NOT_ALIGNED;
          end
        end
      end
      ns      = 64'(secs) * 64'(NS_PER_SEC) + 64'(us) * 64'(NS_PER_US);
      v.ts_ns = ns[TS_W-1:0];
      return v;
    endfunction

    // Note one accepted input transaction
    function void note_byte(logic [7:0] b, logic last, logic [31:0] secs, logic [19:0] us);
      if (pos < MAX_CAPTURE_DEF) begin
        take_byte(pos, b);
        pos++;
      end
      if (last) begin
        due.push_back(judge(secs, us));
        clear_frame();
      end
    endfunction

    // Check one accepted result transaction against the oldest verdict
    function void check_result(logic [87:0] data, logic [2:0] user);
      verdict_t want;
      if (due.size() == 0) begin
        $error("result with no frame pending: frame_status %0d", user);
        errors++;
        return;
      end
      want = due.pop_front();
      if (user !== want.status) begin
        $error("frame_status: expected %0d, got %0d", want.status, user);
        errors++;
      end
      if (data[15:0] !== want.offset) begin
        $error("payload_offset: expected %0d, got %0d", want.offset, data[15:0]);
        errors++;
      end
      if (data[24:16] !== want.count) begin
        $error("packet_count: expected %0d, got %0d", want.count, data[24:16]);
        errors++;
      end
      if (data[86:25] !== want.ts_ns) begin
        $error("timestamp_ns: expected %0d, got %0d", want.ts_ns, data[86:25]);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tsdf_pkg::*;
  import deframer_check_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;     // margin for the result pipe to empty
  localparam int unsigned HOLD_CYCLES    = 500;   // long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all

  typedef logic [7:0] byte_q_t[$];

  // Ways of spoiling an otherwise well-formed frame
  typedef enum int {
    MG_NONE,
    MG_VERSION,
    MG_PROTO,
    MG_UDP_SHORT,
    MG_UDP_LONG,
    MG_MISALIGN,
    MG_TRUNCATE,
    MG_NOISE
  } mangle_t;

  typedef struct {
    link_kind_t  kind;
    bit          vlan;
    int unsigned ihl;
    bit          rtp;
    int unsigned csrc;
    bit          ext;
    int unsigned ext_words;
    int unsigned n_pkts;
    mangle_t     mangle;
    int unsigned pad;
  } frame_shape_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata    = '0;   // data_byte[7:0], capture_seconds[39:8], capture_micros[59:40]
  logic        in_tlast    = 1'b0; // last_byte
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [87:0] out_tdata;          // payload_offset[15:0], packet_count[24:16], timestamp_ns[86:25]
  logic [2:0]  out_tuser;          // frame_status[2:0]
  logic        cfg_wr_en   = 1'b0;
  logic [1:0]  cfg_wr_data = '0;   // link_kind

  frame_verdict_board board = new();

  // Idling controls shared between the stimulus and the receiver
  int unsigned tx_gap_pct   = 0;
  int unsigned rx_stall_pct = 0;
  bit          quiet        = 1'b0;
  bit          hold_req     = 1'b0;
  int unsigned stalled_cycles = 0;

  ts_over_udp_rtp_deframer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: sample both channels at the edge, before anything driven at that edge lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        board.note_byte(in_tdata[7:0], in_tlast, in_tdata[39:8], in_tdata[59:40]);
      if (out_tvalid && out_tready)
        board.check_result(out_tdata, out_tuser);
    end
  end

  // Watchdog: give up once nothing has moved on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stalled_cycles = 0;
    else
      stalled_cycles++;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < rx_stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one byte, perhaps after an idle burst, and hold it until the transaction completes.
  // Leave tvalid high on return; the next caller either keeps it or drops it.
  task automatic send_item(input logic [7:0] b, input logic last,
                           input logic [31:0] secs, input logic [19:0] us);
    if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, us, secs, b};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Send a run of bytes; mark the final one as the frame end when closes is set.
  // Capture time is random on every byte unless pinned for the closing one.
  task automatic send_run(input byte_q_t bytes, input bit closes, input bit pin_time,
                          input logic [31:0] secs, input logic [19:0] us);
    logic        end_here;
    logic [31:0] s;
    logic [19:0] u;
    foreach (bytes[i]) begin
      end_here = closes && (i == bytes.size() - 1);
      s = $urandom;
      u = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 999999));
      if (end_here && pin_time) begin
        s = secs;
        u = us;
      end
      send_item(bytes[i], end_here, s, u);
    end
  endtask

  // Drop tvalid and hold off until every verdict has come back and the pipe has settled
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the link kind once the block is idle
  task automatic set_link(input link_kind_t k);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    board.link_kind = k;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic frame_shape_t plain_shape(link_kind_t kind, int unsigned n);
    frame_shape_t sh;
    sh.kind      = kind;
    sh.vlan      = 1'b0;
    sh.ihl       = 5;
    sh.rtp       = 1'b0;
    sh.csrc      = 0;
    sh.ext       = 1'b0;
    sh.ext_words = 0;
    sh.n_pkts    = n;
    sh.mangle    = MG_NONE;
    sh.pad       = 0;
    return sh;
  endfunction

  // Mostly well-formed frames with random content; about a third spoilt in some way
  function automatic frame_shape_t random_shape(link_kind_t kind);
    frame_shape_t sh;
    int unsigned  roll;
    roll = $urandom_range(0, 11);
    sh = plain_shape(kind, (roll == 0) ? 0 : (roll == 1) ? $urandom_range(2, 4) : 1);
    sh.vlan = (kind == LK_ETHERNET) && ($urandom_range(0, 3) == 0);
    roll = $urandom_range(0, 9);
    sh.ihl = (roll < 8) ? 5 : (roll == 8) ? $urandom_range(6, 15) : $urandom_range(0, 4);
    sh.rtp = $urandom_range(0, 1);
    sh.csrc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
    sh.ext = ($urandom_range(0, 2) == 0);
    sh.ext_words = $urandom_range(0, 8);
    sh.pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
    if ($urandom_range(0, 99) >= 70)
      sh.mangle = mangle_t'($urandom_range(MG_VERSION, MG_NOISE));
    return sh;
  endfunction

  // Lay out link header, IPv4, UDP and optional RTP over random filler bytes
  task automatic make_frame(input frame_shape_t sh, output byte_q_t f);
    int unsigned ip_at, udp_at, pay_at, rl, plen, total, udp_len, extra, cut;
    f.delete();
    case (sh.kind)
      LK_ETHERNET: begin
        repeat (ETH_TYPE_HI_AT) f.push_back(8'($urandom));
        if (sh.vlan) begin
          f.push_back(VLAN_TPID[15:8]);
          f.push_back(VLAN_TPID[7:0]);
          f.push_back(8'($urandom));
          f.push_back(8'($urandom));
        end
        f.push_back(8'h08);
        f.push_back(8'h00);
      end
      LK_LOOPBACK: repeat (LOOP_HDR_BYTES) f.push_back(8'($urandom));
      LK_COOKED: begin
        repeat (COOKED_HDR_BYTES - 2) f.push_back(8'($urandom));
        f.push_back(8'h08);
        f.push_back(8'h00);
      end
      default: repeat (ETH_HDR_BYTES) f.push_back(8'($urandom));
    endcase
    ip_at  = f.size();
    udp_at = ip_at + 4 * sh.ihl;
    pay_at = udp_at + UDP_HDR_BYTES;
    rl = 0;
    if (sh.rtp)
      rl = RTP_FIXED_BYTES + 4 * sh.csrc + (sh.ext ? RTP_EXT_HDR + 4 * sh.ext_words : 0);
    plen  = rl + TS_PACKET_BYTES * sh.n_pkts;
    total = pay_at + plen;
    if (total < ip_at + IPV4_MIN_HDR) total = ip_at + IPV4_MIN_HDR;
    while (f.size() < total + sh.pad) f.push_back(8'($urandom));
    // a short IHL lets the UDP fields land on top of the IP header; later writes win
    f[ip_at] = {IPV4_VERSION, 4'(sh.ihl)};
    f[ip_at + IP_PROTO_AT] = IP_PROTO_UDP;
    udp_len = UDP_HDR_BYTES + plen;
    if (sh.rtp) begin
      f[pay_at] = 8'h80 | (sh.ext ? 8'h10 : 8'h00) | 8'(sh.csrc);
      if (sh.ext) begin
        f[pay_at + RTP_EXT_LEN_AT + 4 * sh.csrc]     = 8'(sh.ext_words >> 8);
        f[pay_at + RTP_EXT_LEN_AT + 4 * sh.csrc + 1] = 8'(sh.ext_words);
      end
    end
    case (sh.mangle)
      MG_VERSION:   f[ip_at] = {IPV4_VERSION ^ 4'($urandom_range(1, 15)), 4'(sh.ihl)};
      MG_PROTO:     f[ip_at + IP_PROTO_AT] = IP_PROTO_UDP ^ 8'($urandom_range(1, 255));
      MG_UDP_SHORT: udp_len = $urandom_range(0, UDP_HDR_BYTES);
      MG_UDP_LONG:  udp_len = f.size() - ip_at + $urandom_range(1, 100);
      MG_MISALIGN: begin
        extra = $urandom_range(1, TS_PACKET_BYTES - 1);
        udp_len += extra;
        repeat (extra) f.push_back(8'($urandom));
      end
      default: ;
    endcase
    f[udp_at + UDP_LEN_AT]     = 8'(udp_len >> 8);
    f[udp_at + UDP_LEN_AT + 1] = 8'(udp_len);
    if (sh.mangle == MG_TRUNCATE) begin
      cut = $urandom_range(1, f.size() - 1);
      while (f.size() > cut) void'(f.pop_back());
    end else if (sh.mangle == MG_NOISE) begin
      f.delete();
      repeat ($urandom_range(1, 80)) f.push_back(8'($urandom));
    end
  endtask

  task automatic run_shape(input frame_shape_t sh);
    byte_q_t f;
    make_frame(sh, f);
    send_run(f, 1'b1, 1'b0, '0, '0);
  endtask

  initial begin
    link_kind_t   plan[8] = '{LK_COOKED, LK_LOOPBACK, LK_ETHERNET, LK_UNSUPPORTED,
                              LK_COOKED, LK_ETHERNET, LK_LOOPBACK, LK_ETHERNET};
    frame_shape_t sh;
    byte_q_t      f, head, tail;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames on the reset link kind, Ethernet
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    set_link(LK_ETHERNET);

    // plain raw TS with the smallest capture time, then a VLAN-tagged one with the largest
    sh = plain_shape(LK_ETHERNET, 1);
    make_frame(sh, f);
    send_run(f, 1'b1, 1'b1, 32'd0, 20'd0);
    sh.vlan   = 1'b1;
    sh.n_pkts = 2;
    make_frame(sh, f);
    send_run(f, 1'b1, 1'b1, 32'hFFFF_FFFF, 20'hF_FFFF);

    // RTP: CSRCs with an extension, the full CSRC list, and a header that eats the payload
    sh = plain_shape(LK_ETHERNET, 1);
    sh.rtp       = 1'b1;
    sh.csrc      = 3;
    sh.ext       = 1'b1;
    sh.ext_words = 2;
    run_shape(sh);
    sh.csrc = 15;
    sh.ext  = 1'b0;
    run_shape(sh);
    sh.csrc      = 0;
    sh.ext       = 1'b1;
    sh.ext_words = 0;
    sh.n_pkts    = 0;
    run_shape(sh);

    // every way of spoiling a frame, once each
    for (int m = MG_VERSION; m <= MG_NOISE; m++) begin
      sh = plain_shape(LK_ETHERNET, 1);
      sh.mangle = mangle_t'(m);
      run_shape(sh);
    end

    // IHL below five overlaps UDP onto IP; the largest IHL carries options
    sh = plain_shape(LK_ETHERNET, 1);
    sh.ihl = 2;
    run_shape(sh);
    sh.ihl = 15;
    run_shape(sh);

    // a frame of a single byte
    f.delete();
    f.push_back(8'($urandom));
    send_run(f, 1'b1, 1'b0, '0, '0);

    // oversized frame: most packets allowed, with bytes past the capture limit dropped
    tx_gap_pct = 0;
    sh = plain_shape(LK_ETHERNET, 348);
    sh.pad = 74;
    run_shape(sh);
    tx_gap_pct = 20;

    // change the link kind mid-frame; the kind latched at the first byte must hold
    sh = plain_shape(LK_ETHERNET, 1);
    make_frame(sh, f);
    head = f[0:29];
    tail = f[30:$];
    send_run(head, 1'b0, 1'b0, '0, '0);
    set_link(LK_LOOPBACK);
    send_run(tail, 1'b1, 1'b0, '0, '0);

    run_shape(plain_shape(LK_LOOPBACK, 1));
    sh = plain_shape(LK_LOOPBACK, 1);
    sh.rtp = 1'b1;
    run_shape(sh);

    set_link(LK_COOKED);
    run_shape(plain_shape(LK_COOKED, 2));
    sh = plain_shape(LK_COOKED, 1);
    sh.rtp       = 1'b1;
    sh.ext       = 1'b1;
    sh.ext_words = 1;
    run_shape(sh);

    set_link(LK_UNSUPPORTED);
    run_shape(plain_shape(LK_ETHERNET, 1));

    // Random phases, one link kind each; the last runs with no idling on either side
    foreach (plan[p]) begin
      set_link(plan[p]);
      quiet        = (p == $size(plan) - 1);
      tx_gap_pct   = 20 * $urandom_range(0, 2);
      rx_stall_pct = 20 * $urandom_range(0, 2);
      if (p == 2) begin
        // hold the receiver off and keep offering frame ends until the input stalls
        hold_req = 1'b1;
        repeat (12) send_item(8'($urandom), 1'b1, $urandom, 20'($urandom_range(0, 999999)));
      end
      repeat (plan[p] == LK_UNSUPPORTED ? 3 : 12)
        run_shape(random_shape(plan[p] == LK_UNSUPPORTED ?
                               link_kind_t'($urandom_range(0, 2)) : plan[p]));
    end

    wait_drained();
    if (board.errors == 0 && board.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
